/* rtl/core/huext_pkg.sv */
`timescale 1ns / 1ps
// huext_pkg: shared codes, register indexes and pattern tables
// for the http url extractor; no dependencies
package huext_pkg;

  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_NOT_TCP   = 3'd1;
  localparam logic [2:0] ST_OTHER     = 3'd2;
  localparam logic [2:0] ST_NO_URL    = 3'd3;
  localparam logic [2:0] ST_BAD_ETHER = 3'd4;
  localparam logic [2:0] ST_HALTED    = 3'd5;
  localparam logic [2:0] ST_SHORT     = 3'd6;

  localparam logic [7:0] REG_PORT_A = 8'd0;
  localparam logic [7:0] REG_PORT_B = 8'd1;

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [1:0] HC_SEARCH = 2'd0;
  localparam logic [1:0] HC_CAP    = 2'd1;
  localparam logic [1:0] HC_CR     = 2'd2;
  localparam logic [1:0] HC_DONE   = 2'd3;

  localparam logic [2:0] GS_CAP  = 3'd4;
  localparam logic [2:0] GS_DONE = 3'd5;

  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_H  = 8'h48;
  localparam logic [7:0] CH_G  = 8'h47;

  localparam logic [15:0] ET_IPV4 = 16'h0800;
  localparam logic [15:0] ET_ARP  = 16'h0806;
  localparam logic [7:0]  PROTO_TCP = 8'h06;

  function automatic logic [7:0] host_char(input logic [2:0] s);
    logic [7:0] c;
    case (s)
      3'd0: c = 8'h48;
      3'd1: c = 8'h6f;
      3'd2: c = 8'h73;
      3'd3: c = 8'h74;
      3'd4: c = 8'h3a;
      3'd5: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] get_char(input logic [1:0] s);
    logic [7:0] c;
    case (s)
      2'd0: c = 8'h47;
      2'd1: c = 8'h45;
      2'd2: c = 8'h54;
      default: c = 8'h20;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/huext_frame.sv */
`timescale 1ns / 1ps
// huext_frame: per-byte frame parser, host/path search and url stores
// depends on huext_pkg
module huext_frame import huext_pkg::*; #(
  parameter int URL_BYTES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        byte_en_i,
  input  logic        rd_en_i,
  input  logic [7:0]  data_i,
  input  logic        last_i,
  input  logic [7:0]  rd_idx_i,
  input  logic [15:0] port_a_i,
  input  logic [15:0] port_b_i,
  output logic [2:0]  status_o,
  output logic [7:0]  sum_len_o,
  output logic [7:0]  rd_len_o,
  output logic [7:0]  rd_byte_o
);

  localparam int LW = $clog2(URL_BYTES);
  localparam int IW = (LW > 8) ? LW : 8;
  localparam logic [LW-1:0] CAP = LW'(URL_BYTES - 1);
  localparam logic [LW-1:0] ONE = LW'(1);

  logic [15:0] bp_q, et_q, dport_q, ps_q;
  logic [3:0]  ihl_q;
  logic [7:0]  proto_q;
  logic        ended_q, crs_q, halt_q;
  logic [2:0]  hstg_q, gstg_q;
  logic [1:0]  hcs_q;
  logic [LW-1:0] hlen_q, plen_q, url_q;

  logic [15:0] bp_n, et_n, dport_n, ps_n;
  logic [3:0]  ihl_n;
  logic [7:0]  proto_n;
  logic        ended_n, crs_n, halt_n;
  logic [2:0]  hstg_n, gstg_n;
  logic [1:0]  hcs_n;
  logic [LW-1:0] hlen_n, plen_n, url_n;

  logic [7:0] host_mem [URL_BYTES];
  logic [7:0] path_mem [URL_BYTES];
  logic       host_we, path_we;
  logic [LW-1:0] host_wa, path_wa;
  logic [7:0] host_wd;

  logic        clr;
  logic [15:0] pos, tp, tp_n, s_off, ps_min;
  logic [16:0] cnt;
  logic        et_ok, et_ok_n;
  logic [LW-1:0] h_fin, p_fin, room, p_cut;
  logic [2:0]  status;

  always_comb begin
    clr     = (bp_q == 16'd0);
    pos     = bp_q;
    et_n    = clr ? 16'd0 : et_q;
    ihl_n   = clr ? 4'd0 : ihl_q;
    proto_n = clr ? 8'd0 : proto_q;
    dport_n = clr ? 16'd0 : dport_q;
    ps_n    = clr ? 16'd0 : ps_q;
    ended_n = clr ? 1'b0 : ended_q;
    hstg_n  = clr ? 3'd0 : hstg_q;
    hcs_n   = clr ? HC_SEARCH : hcs_q;
    crs_n   = clr ? 1'b0 : crs_q;
    hlen_n  = clr ? '0 : hlen_q;
    gstg_n  = clr ? 3'd0 : gstg_q;
    plen_n  = clr ? '0 : plen_q;
    url_n   = clr ? '0 : url_q;
    halt_n  = halt_q;
    host_we = 1'b0;
    path_we = 1'b0;
    host_wa = hlen_n;
    path_wa = plen_n;
    host_wd = data_i;
    et_ok   = (et_n == ET_IPV4) || (et_n == ET_ARP);
    tp      = 16'd14 + {10'd0, ihl_n, 2'b00};
    s_off   = tp + {10'd0, data_i[7:4], 2'b00};
    ps_min  = tp + 16'd13;

    if (pos == 16'd12) begin
      et_n = {data_i, 8'h00};
    end else if (pos == 16'd13) begin
      et_n = et_n | {8'h00, data_i};
    end else if (pos >= 16'd14 && et_ok) begin
      if (pos == 16'd14) begin
        ihl_n = data_i[3:0];
      end else if (pos == 16'd23) begin
        proto_n = data_i;
      end else if (pos == tp + 16'd2) begin
        dport_n = {data_i, 8'h00};
      end else if (pos == tp + 16'd3) begin
        dport_n = dport_n | {8'h00, data_i};
      end else if (pos == tp + 16'd12) begin
        ps_n = (s_off > ps_min) ? s_off : ps_min;
      end else if (ps_n != 16'd0 && pos >= ps_n && !ended_n) begin
        if (data_i == 8'h00) begin
          ended_n = 1'b1;
        end else begin
          case (hcs_n)
            HC_SEARCH: begin
              if (data_i == host_char(hstg_n)) begin
                if (hstg_n == 3'd5) hcs_n = HC_CAP;
                hstg_n = hstg_n + 3'd1;
              end else begin
                hstg_n = (data_i == CH_H) ? 3'd1 : 3'd0;
              end
            end
            HC_CAP: begin
              // a cr is stored at once and dropped again if lf follows
              if (data_i == CH_CR) hcs_n = HC_CR;
              if (hlen_n < CAP) begin
                host_we = 1'b1;
                hlen_n  = hlen_n + ONE;
                crs_n   = 1'b1;
              end else begin
                crs_n = 1'b0;
              end
            end
            HC_CR: begin
              if (data_i == CH_LF) begin
                hcs_n = HC_DONE;
                if (crs_n) hlen_n = hlen_n - ONE;
              end else begin
                if (data_i != CH_CR) hcs_n = HC_CAP;
                if (hlen_n < CAP) begin
                  host_we = 1'b1;
                  hlen_n  = hlen_n + ONE;
                  crs_n   = 1'b1;
                end else begin
                  crs_n = 1'b0;
                end
              end
            end
            default: ;
          endcase
          if (gstg_n < GS_CAP) begin
            if (data_i == get_char(gstg_n[1:0])) gstg_n = gstg_n + 3'd1;
            else gstg_n = (data_i == CH_G) ? 3'd1 : 3'd0;
          end else if (gstg_n == GS_CAP) begin
            if (data_i == CH_SP) begin
              gstg_n = GS_DONE;
            end else if (plen_n < CAP) begin
              path_we = 1'b1;
              plen_n  = plen_n + ONE;
            end
          end
        end
      end
    end
    bp_n = (bp_q != 16'hffff) ? bp_q + 16'd1 : bp_q;

    // end of frame checks
    cnt     = {1'b0, pos} + 17'd1;
    et_ok_n = (et_n == ET_IPV4) || (et_n == ET_ARP);
    tp_n    = 16'd14 + {10'd0, ihl_n, 2'b00};
    h_fin   = (hcs_n == HC_DONE) ? hlen_n : '0;
    p_fin   = (gstg_n == GS_DONE) ? plen_n : '0;
    room    = CAP - h_fin;
    p_cut   = (p_fin > room) ? room : p_fin;
    status  = ST_FOUND;
    if (cnt < 17'd14) begin
      status = ST_SHORT;
    end else if (!et_ok_n) begin
      status = ST_BAD_ETHER;
    end else if (cnt < 17'd24) begin
      status = ST_SHORT;
    end else if (proto_n != PROTO_TCP) begin
      status = ST_NOT_TCP;
    end else if (cnt < {1'b0, tp_n} + 17'd4) begin
      status = ST_SHORT;
    end else if (dport_n != port_a_i && dport_n != port_b_i) begin
      status = ST_OTHER;
    end else if (ps_n == 16'd0) begin
      status = ST_SHORT;
    end else begin
      hlen_n = h_fin;
      plen_n = p_cut;
      url_n  = h_fin + p_cut;
      status = (url_n != '0) ? ST_FOUND : ST_NO_URL;
    end
    if (last_i) begin
      bp_n = 16'd0;
      if (status != ST_FOUND) url_n = '0;
      if (status == ST_BAD_ETHER) halt_n = 1'b1;
    end else begin
      hlen_n = (host_we && hcs_n != HC_DONE) ? hlen_n : hlen_n;
    end
  end

  // restore lengths touched only by the end-of-frame path when not last
  logic [LW-1:0] hlen_w, plen_w, url_w;
  logic [LW-1:0] hlen_run, plen_run;
  always_comb begin
    hlen_run = clr ? '0 : hlen_q;
    plen_run = clr ? '0 : plen_q;
    if (host_we) hlen_run = host_wa + ONE;
    if (hcs_n == HC_DONE && (clr ? HC_SEARCH : hcs_q) == HC_CR && crs_n && !host_we)
      hlen_run = host_wa - ONE;
    if (path_we) plen_run = path_wa + ONE;
    hlen_w = last_i ? hlen_n : hlen_run;
    plen_w = last_i ? plen_n : plen_run;
    url_w  = last_i ? url_n : (clr ? '0 : url_q);
  end

  assign status_o  = halt_q ? ST_HALTED : status;
  assign sum_len_o = halt_q ? 8'(url_q) : 8'(url_w);
  assign rd_len_o  = 8'(url_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp_q <= '0; et_q <= '0; ihl_q <= '0; proto_q <= '0; dport_q <= '0;
      ps_q <= '0; ended_q <= 1'b0; hstg_q <= '0; hcs_q <= HC_SEARCH;
      crs_q <= 1'b0; hlen_q <= '0; gstg_q <= '0; plen_q <= '0;
      url_q <= '0; halt_q <= 1'b0;
    end else if (byte_en_i) begin
      if (halt_q) begin
        if (last_i) bp_q <= '0;
      end else begin
        bp_q <= bp_n; et_q <= et_n; ihl_q <= ihl_n; proto_q <= proto_n;
        dport_q <= dport_n; ps_q <= ps_n; ended_q <= ended_n;
        hstg_q <= hstg_n; hcs_q <= hcs_n; crs_q <= crs_n;
        hlen_q <= hlen_w; gstg_q <= gstg_n; plen_q <= plen_w;
        url_q <= url_w; halt_q <= halt_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_en_i && !halt_q && host_we) host_mem[host_wa] <= host_wd;
    if (byte_en_i && !halt_q && path_we) path_mem[path_wa] <= data_i;
  end

  // url read: one registered read from each store
  logic [IW-1:0] idx_w;
  logic          in_rng, sel_host, in_rng_q, sel_host_q;
  logic [LW-1:0] h_addr, p_addr;
  logic [7:0]    host_rd_q, path_rd_q;

  always_comb begin
    idx_w    = IW'(rd_idx_i);
    in_rng   = idx_w < IW'(url_q);
    sel_host = idx_w < IW'(hlen_q);
    h_addr   = idx_w[LW-1:0];
    p_addr   = LW'(idx_w - IW'(hlen_q));
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      host_rd_q  <= host_mem[h_addr];
      path_rd_q  <= path_mem[p_addr];
      in_rng_q   <= in_rng;
      sel_host_q <= sel_host;
    end
  end

  assign rd_byte_o = !in_rng_q ? 8'h00 : (sel_host_q ? host_rd_q : path_rd_q);

endmodule

/* rtl/core/http_url_extractor_unit.sv */
`timescale 1ns / 1ps
// http url extractor top level: one item per cycle while the output is not stalled; each
// input transaction passes a parse/read stage, then an output register, to its result
// throughput set by the per-byte parser and one store read port
// reset clears frame state, halt flag, ports (80, 8080); url stores are not cleared
// depends on huext_pkg and huext_frame
module http_url_extractor_unit import huext_pkg::*; #(
  parameter int URL_BYTES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // data_byte[7:0], read_index[15:8]
  input  logic        s_axis_tuser,   // op
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // status[2:0], url_length[10:3], url_byte[18:11]
  output logic        m_axis_tuser,   // kind
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] port_a_q, port_b_q;
  logic        adv, acc, emit;
  logic [2:0]  status;
  logic [7:0]  sum_len, rd_len, rd_byte;
  logic        s1_valid_q, s1_kind_q;
  logic [2:0]  s1_status_q;
  logic [7:0]  s1_len_q;
  logic        m_valid_q, m_kind_q;
  logic [18:0] m_data_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_a_q <= 16'd80;
      port_b_q <= 16'd8080;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_PORT_A) port_a_q <= cfg_data_i;
      if (cfg_index_i == REG_PORT_B) port_b_q <= cfg_data_i;
    end
  end

  assign adv           = !m_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign acc           = s_axis_tvalid && adv;
  assign emit          = (s_axis_tuser == OP_READ) || s_axis_tlast;

  huext_frame #(.URL_BYTES(URL_BYTES)) u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_en_i (acc && s_axis_tuser == OP_FRAME),
    .rd_en_i   (acc && s_axis_tuser == OP_READ),
    .data_i    (s_axis_tdata[7:0]),
    .last_i    (s_axis_tlast),
    .rd_idx_i  (s_axis_tdata[15:8]),
    .port_a_i  (port_a_q),
    .port_b_i  (port_b_q),
    .status_o  (status),
    .sum_len_o (sum_len),
    .rd_len_o  (rd_len),
    .rd_byte_o (rd_byte)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= acc && emit;
      m_valid_q  <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_kind_q   <= s_axis_tuser;
      s1_status_q <= (s_axis_tuser == OP_READ) ? ST_FOUND : status;
      s1_len_q    <= (s_axis_tuser == OP_READ) ? rd_len : sum_len;
      m_kind_q    <= s1_kind_q;
      m_data_q    <= {(s1_kind_q ? rd_byte : 8'h00), s1_len_q, s1_status_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tdata  = {5'd0, m_data_q};

endmodule
